// File: hdl/dsc_pkg.sv
// Shared constants and types of the DAC step current regulator.
package dsc_pkg;

    // Field widths of the request and result channels.
    localparam int OPCODE_W       = 2;
    localparam int SENSE_MV_W     = 13;
    localparam int ENC_COUNT_W    = 8;
    localparam int TARGET_REQ_W   = 16;
    localparam int TARGET_W       = 15;
    localparam int SENSED_W       = 15;

    // Configuration register widths and port layout.
    localparam int GAIN_W         = 16;
    localparam int OFFSET_W       = 11;
    localparam int FULL_SCALE_W   = 15;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;

    // Calibration and regulation constants.
    localparam int FRAC_BITS      = 12;
    localparam int STEP_MARGIN_MA = 50;
    localparam int ENC_HALF_W     = ENC_COUNT_W - 1;
    localparam int ENC_SQ_W       = 13;

    localparam logic [GAIN_W-1:0]       GAIN_RESET       = 16'd4096;
    localparam logic [OFFSET_W-1:0]     OFFSET_RESET     = 11'd0;
    localparam logic [TARGET_W-1:0]     TARGET_MAX_RESET = 15'd2500;
    localparam logic [FULL_SCALE_W-1:0] FULL_SCALE_RESET = 15'd1500;
    localparam logic [SENSED_W-1:0]     SENSED_MAX       = 15'h7FFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK    = 2'd0,
        OP_ENCODER = 2'd1,
        OP_SET     = 2'd2
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN       = 2'd0,
        CFG_OFFSET     = 2'd1,
        CFG_TARGET_MAX = 2'd2,
        CFG_FULL_SCALE = 2'd3
    } t_cfg_index;

endpackage

// File: hdl/dsc_if.sv
// Request and result channel interfaces of the DAC step current regulator.
interface dsc_in_if import dsc_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic [OPCODE_W-1:0]            opcode;
    logic [SENSE_MV_W-1:0]          sense_mv;
    logic signed [ENC_COUNT_W-1:0]  encoder_count;
    logic signed [TARGET_REQ_W-1:0] target_request_ma;

    modport source (output valid, output opcode, output sense_mv, output encoder_count,
                    output target_request_ma, input ready);
    modport sink (input valid, input opcode, input sense_mv, input encoder_count,
                  input target_request_ma, output ready);
endinterface

interface dsc_out_if import dsc_pkg::*; #(parameter int CODE_W = 12) ();
    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   dac_code;
    logic [TARGET_W-1:0] target_ma;
    logic [SENSED_W-1:0] sensed_ma;
    logic                encoder_consumed;

    modport source (output valid, output dac_code, output target_ma, output sensed_ma,
                    output encoder_consumed, input ready);
    modport sink (input valid, input dac_code, input target_ma, input sensed_ma,
                  input encoder_consumed, output ready);
endinterface

// File: hdl/dac_step_current_regulator_top.sv
// Top level of the DAC step current regulator.
// A request is taken into the input register, and its result into the output register.
// Throughput: one request per cycle unless results stall; the state loop never waits.
// A stalled result holds the output register and, through it, the input register.
// Reset (synchronous, active low) clears the DAC code and target to zero and loads the
// calibration registers with their defaults; the block is ready right after reset.
module dac_step_current_regulator_top import dsc_pkg::*; #(
    parameter int DAC_CODE_MAX = 4095
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    dsc_in_if.sink                 i_in,
    dsc_out_if.source              o_out
);

    // The DAC code is as wide as its largest value needs.  The product width covers both
    // code * full scale (plus one step) and (target + margin) * DAC_CODE_MAX.
    localparam int CODE_W    = $clog2(DAC_CODE_MAX + 1);
    localparam int PROD_W    = CODE_W + FULL_SCALE_W + 2;
    localparam int MV_GAIN_W = SENSE_MV_W + GAIN_W;
    localparam int CAL_W     = MV_GAIN_W - FRAC_BITS;
    localparam int SUM_W     = CAL_W + 2;
    localparam int TSUM_W    = TARGET_W + 2;

    localparam logic [CODE_W-1:0] CODE_MAX_C = CODE_W'(DAC_CODE_MAX);
    localparam logic [PROD_W-1:0] K_P        = PROD_W'(DAC_CODE_MAX);
    localparam logic [PROD_W-1:0] MARGIN_P   = PROD_W'(STEP_MARGIN_MA);
    localparam logic [PROD_W-1:0] MARGIN_M1  = PROD_W'(STEP_MARGIN_MA - 1);
    localparam logic [TARGET_W-1:0] MARGIN_T = TARGET_W'(STEP_MARGIN_MA);

    // ------------------------------------------------------------------
    // Configuration registers.  Writes must arrive only while idle; not enforced.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]         r_gain;
    logic signed [OFFSET_W-1:0] r_offset;
    logic [TARGET_W-1:0]       r_tmax;
    logic [FULL_SCALE_W-1:0]   r_fs;
    logic                      r_refresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_RESET;
            r_offset  <= OFFSET_RESET;
            r_tmax    <= TARGET_MAX_RESET;
            r_fs      <= FULL_SCALE_RESET;
            r_refresh <= 1'b0;
        end else begin
            r_refresh <= 1'b0;
            if (i_cfg_wr_en) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_GAIN:       r_gain   <= i_cfg_wdata;
                    CFG_OFFSET:     r_offset <= i_cfg_wdata[OFFSET_W-1:0];
                    CFG_TARGET_MAX: r_tmax   <= i_cfg_wdata[TARGET_W-1:0];
                    CFG_FULL_SCALE: begin
                        r_fs      <= i_cfg_wdata[FULL_SCALE_W-1:0];
                        // The tracked code * full-scale product must be rebuilt.
                        r_refresh <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake.  The input register and the output register form a
    // two-stage pipe; each stage takes a new request when it empties.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_o_valid;
    logic out_free;
    logic s1_adv;
    logic in_acc;

    assign out_free   = !r_o_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register.  The two multiplications that depend only on the
    // request (sensed voltage times gain, and the squared half count of the
    // encoder) are done here so that the state loop holds no multiplier.
    // ------------------------------------------------------------------
    logic [OPCODE_W-1:0]            r_s1_op;
    logic [MV_GAIN_W-1:0]           r_s1_mv_gain;
    logic [ENC_SQ_W-1:0]            r_s1_enc_sq;
    logic                           r_s1_enc_neg;
    logic                           r_s1_enc_apply;
    logic signed [TARGET_REQ_W-1:0] r_s1_req;

    logic [ENC_COUNT_W-1:0] enc_mag;
    logic [ENC_HALF_W-1:0]  enc_half;
    logic [2*ENC_HALF_W-1:0] enc_sq_full;

    // The magnitude of -128 is 128, which still fits the unsigned 8-bit value.
    assign enc_mag     = i_in.encoder_count[ENC_COUNT_W-1] ?
                         ENC_COUNT_W'(-i_in.encoder_count) : i_in.encoder_count;
    // Halving the magnitude truncates toward zero, as the division does for either sign.
    assign enc_half    = enc_mag[ENC_COUNT_W-1:1];
    assign enc_sq_full = enc_half * enc_half;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op        <= i_in.opcode;
            r_s1_mv_gain   <= MV_GAIN_W'(i_in.sense_mv) * MV_GAIN_W'(r_gain);
            r_s1_enc_sq    <= enc_sq_full[ENC_SQ_W-1:0];
            r_s1_enc_neg   <= i_in.encoder_count[ENC_COUNT_W-1];
            r_s1_enc_apply <= enc_mag > ENC_COUNT_W'(1);
            r_s1_req       <= i_in.target_request_ma;
        end
    end

    // ------------------------------------------------------------------
    // State: DAC code, target, and the product code * full scale, which is
    // kept up to date by adding or subtracting the full scale on each step.
    // ------------------------------------------------------------------
    logic [CODE_W-1:0]   r_dac;
    logic [TARGET_W-1:0] r_target;
    logic [PROD_W-1:0]   r_prod;
    logic [SENSED_W-1:0] r_o_sensed;
    logic                r_o_consumed;

    logic [CODE_W-1:0]   n_dac;
    logic [TARGET_W-1:0] n_target;
    logic [PROD_W-1:0]   n_prod;
    logic [SENSED_W-1:0] n_sensed;
    logic                n_consumed;

    // Calibration: (mV * gain) >> 12 plus the signed offset, clamped to the 15-bit range.
    logic signed [SUM_W-1:0] cal_sum;
    logic [SENSED_W-1:0]     sensed;

    assign cal_sum = $signed({1'b0, r_s1_mv_gain[MV_GAIN_W-1:FRAC_BITS]}) +
                     SUM_W'(r_offset);

    always_comb begin
        if (cal_sum[SUM_W-1]) begin
            sensed = '0;
        end else if (cal_sum[SUM_W-2:SENSED_W] != '0) begin
            sensed = SENSED_MAX;
        end else begin
            sensed = cal_sum[SENSED_W-1:0];
        end
    end

    // Overshoot checks without a divider.  With K = DAC_CODE_MAX and P = code * F:
    //   stepping up is fine when floor((P + F) / K) < T + 50, i.e. P + F < (T + 50) * K;
    //   stepping down is fine when the estimate at code - 1 is at least T - 49, i.e.
    //   P - F >= (T - 49) * K, always true for a target of 49 or less.
    // At code zero the estimate below is -floor(F / K), truncated toward zero, so the
    // down step is fine only when F < (50 - T) * K for a target under 50.
    logic up_ok;
    logic down_ok;
    logic tgt_low;

    assign tgt_low = r_target < MARGIN_T;
    assign up_ok   = (r_prod + PROD_W'(r_fs)) < ((PROD_W'(r_target) + MARGIN_P) * K_P);

    always_comb begin
        if (r_dac != '0) begin
            down_ok = (r_target <= TARGET_W'(STEP_MARGIN_MA - 1)) ||
                      ((r_prod - PROD_W'(r_fs)) >=
                       ((PROD_W'(r_target) - MARGIN_M1) * K_P));
        end else begin
            down_ok = tgt_low &&
                      (PROD_W'(r_fs) < ((MARGIN_P - PROD_W'(r_target)) * K_P));
        end
    end

    // Target update for encoder and set requests, clamped to 0..target_max.
    logic signed [TSUM_W-1:0] enc_sum;
    logic [TARGET_W-1:0]      enc_target;
    logic [TARGET_W-1:0]      set_target;

    assign enc_sum = r_s1_enc_neg ?
                     $signed({2'b00, r_target}) - $signed(TSUM_W'(r_s1_enc_sq)) :
                     $signed({2'b00, r_target}) + $signed(TSUM_W'(r_s1_enc_sq));

    always_comb begin
        if (enc_sum[TSUM_W-1]) begin
            enc_target = '0;
        end else if (enc_sum[TSUM_W-2:0] > {1'b0, r_tmax}) begin
            enc_target = r_tmax;
        end else begin
            enc_target = enc_sum[TARGET_W-1:0];
        end
        if (r_s1_req[TARGET_REQ_W-1]) begin
            set_target = '0;
        end else if (r_s1_req[TARGET_W-1:0] > r_tmax) begin
            set_target = r_tmax;
        end else begin
            set_target = r_s1_req[TARGET_W-1:0];
        end
    end

    always_comb begin
        logic step_up;
        logic step_dn;
        n_dac      = r_dac;
        n_prod     = r_prod;
        n_target   = r_target;
        n_sensed   = '0;
        n_consumed = 1'b0;
        step_up    = 1'b0;
        step_dn    = 1'b0;
        case (t_opcode'(r_s1_op))
            OP_TICK: begin
                n_sensed = sensed;
                if (r_target > sensed) begin
                    step_up = up_ok;
                    step_dn = !up_ok;
                end else if (r_target < sensed) begin
                    step_dn = down_ok;
                    step_up = !down_ok;
                end
                // Saturation at either end leaves the code, and so the product, as is.
                if (step_up && (r_dac != CODE_MAX_C)) begin
                    n_dac  = r_dac + CODE_W'(1);
                    n_prod = r_prod + PROD_W'(r_fs);
                end else if (step_dn && (r_dac != '0)) begin
                    n_dac  = r_dac - CODE_W'(1);
                    n_prod = r_prod - PROD_W'(r_fs);
                end
            end
            OP_ENCODER: begin
                if (r_s1_enc_apply) begin
                    n_target   = enc_target;
                    n_consumed = 1'b1;
                end
            end
            OP_SET: begin
                n_target = set_target;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac    <= '0;
            r_target <= '0;
            r_prod   <= '0;
        end else if (r_refresh) begin
            // After full-scale writes; the user must keep the block idle (unenforced).
            r_prod <= PROD_W'(r_dac) * PROD_W'(r_fs);
        end else if (s1_adv) begin
            r_dac    <= n_dac;
            r_target <= n_target;
            r_prod   <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_sensed   <= n_sensed;
            r_o_consumed <= n_consumed;
        end
    end

    // The DAC code and target registers only change as a result is loaded, so they
    // double as the output register for the DAC code and target.
    assign o_out.valid            = r_o_valid;
    assign o_out.dac_code         = r_dac;
    assign o_out.target_ma        = r_target;
    assign o_out.sensed_ma        = r_o_sensed;
    assign o_out.encoder_consumed = r_o_consumed;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_prod_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_refresh |-> (r_prod == PROD_W'(r_dac) * PROD_W'(r_fs)))
        else $error("tracked DAC product out of step with the DAC code");

    a_dac_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> $stable(r_dac))
        else $error("DAC code changed without a result being loaded");

    a_consumed_no_sense: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.encoder_consumed) |-> (o_out.sensed_ma == '0))
        else $error("encoder result carries a sensed current");

    a_target_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && ((r_s1_op == OP_SET) || ((r_s1_op == OP_ENCODER) && r_s1_enc_apply)))
        |=> (r_target <= r_tmax))
        else $error("target above its limit after a target update");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_in.ready)
        else $error("request refused with an empty input register");

endmodule

// File: tb/dac_step_current_regulator_top_tb.sv
// Self-checking testbench of the DAC step current regulator, predicting every result.
`timescale 1ns / 100ps

module dac_step_current_regulator_top_tb;
    import dsc_pkg::*;

    // The block is built with its default DAC range, so the code is 12 bits wide.
    localparam int DAC_CODE_MAX = 4095;
    localparam int CODE_W       = 12;

    // Opcode 3 has no meaning; the block must report its state unchanged.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // Settling time after the last result, before the registers are written again.
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 160;
    localparam int SHOWN_ERRORS = 100;
    localparam int RAMP_TICKS   = 150;

    typedef struct packed {
        logic [OPCODE_W-1:0]            opcode;
        logic [SENSE_MV_W-1:0]          sense_mv;
        logic signed [ENC_COUNT_W-1:0]  encoder_count;
        logic signed [TARGET_REQ_W-1:0] target_request_ma;
    } t_request;

    typedef struct packed {
        logic [CODE_W-1:0]   dac_code;
        logic [TARGET_W-1:0] target_ma;
        logic [SENSED_W-1:0] sensed_ma;
        logic                encoder_consumed;
    } t_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    dsc_in_if                      in_if ();
    dsc_out_if #(.CODE_W(CODE_W))  out_if ();

    dac_step_current_regulator_top #(
        .DAC_CODE_MAX (DAC_CODE_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Requests waiting to be offered, and the results the regulator owes us, oldest first.
    t_request requests_pending[$];
    t_result  results_due[$];

    // Our own copy of the calibration registers and of the regulator state.
    longint cal_gain;
    longint cal_offset;
    longint target_limit;
    longint full_scale;
    longint model_dac;
    longint model_target;

    // Bookkeeping for the closing summary.
    int ticks_seen;
    int encoder_applied;
    int sets_seen;
    int unused_seen;
    int step_backs;
    int dac_saturations;
    int results_seen;
    int mismatches;
    int cfg_phases;
    int cycle_count;

    // Sender and receiver pacing.
    bit       sender_steady;
    t_request offered;
    int       burst_left;
    int       gap_left;
    int       stall_mode;
    int       mode_timer;
    int       hold_left;
    bit       take_result;

    // The clock: 6 ns low, then 6 ns high.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // A hard ceiling on the run, so that a hung handshake cannot stall the simulation.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results still due.",
                     cycle_count, results_due.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Current implied by a DAC code; the division truncates towards zero, also for code -1.
    function automatic longint dac_estimate_ma(input longint code);
        return code * full_scale / DAC_CODE_MAX;
    endfunction

    // Applies one request to our copy of the regulator and returns the result it should give.
    function automatic t_result regulate(input t_request r);
        longint  sensed;
        longint  next_code;
        longint  count;
        longint  half;
        longint  delta;
        t_result res;

        sensed = 0;
        res.encoder_consumed = 1'b0;
        case (r.opcode)
            OP_TICK: begin
                sensed = ((longint'(r.sense_mv) * cal_gain) >>> FRAC_BITS) + cal_offset;
                sensed = clamp(sensed, 0, longint'(SENSED_MAX));
                next_code = model_dac;
                // Step towards the target, but back off if the stepped code would overshoot
                // it by the margin or more.
                if (model_target > sensed) begin
                    if (dac_estimate_ma(model_dac + 1) - model_target < STEP_MARGIN_MA) begin
                        next_code = model_dac + 1;
                    end else begin
                        next_code = model_dac - 1;
                        step_backs++;
                    end
                end else if (model_target < sensed) begin
                    if (model_target - dac_estimate_ma(model_dac - 1) < STEP_MARGIN_MA) begin
                        next_code = model_dac - 1;
                    end else begin
                        next_code = model_dac + 1;
                        step_backs++;
                    end
                end
                if (next_code < 0 || next_code > DAC_CODE_MAX) begin
                    dac_saturations++;
                end
                model_dac = clamp(next_code, 0, DAC_CODE_MAX);
                ticks_seen++;
            end
            OP_ENCODER: begin
                count = r.encoder_count;
                // Counts of -1, 0 and 1 are left for the encoder to accumulate further.
                if (count > 1 || count < -1) begin
                    half = count / 2;
                    delta = half * half;
                    if (count < 0) begin
                        delta = -delta;
                    end
                    model_target = clamp(model_target + delta, 0, target_limit);
                    res.encoder_consumed = 1'b1;
                    encoder_applied++;
                end
            end
            OP_SET: begin
                model_target = clamp(longint'(r.target_request_ma), 0, target_limit);
                sets_seen++;
            end
            default: begin
                unused_seen++;
            end
        endcase
        res.dac_code  = CODE_W'(model_dac);
        res.target_ma = TARGET_W'(model_target);
        res.sensed_ma = SENSED_W'(sensed);
        return res;
    endfunction

    // Builds a request whose meaningful field is given; the fields the opcode ignores are
    // filled with noise, which the block must not react to.
    function automatic t_request shaped(input logic [OPCODE_W-1:0] op, input int value);
        t_request r;

        r.opcode            = op;
        r.sense_mv          = SENSE_MV_W'($urandom);
        r.encoder_count     = ENC_COUNT_W'($urandom);
        r.target_request_ma = TARGET_REQ_W'($urandom);
        case (op)
            OP_TICK:    r.sense_mv          = SENSE_MV_W'(value);
            OP_ENCODER: r.encoder_count     = ENC_COUNT_W'(value);
            OP_SET:     r.target_request_ma = TARGET_REQ_W'(value);
            default: ;
        endcase
        return r;
    endfunction

    // A random request, mostly within the documented ranges and now and then across the
    // whole width of its field.
    function automatic t_request random_request();
        int pick;
        int value;

        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            value = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                : $urandom_range(0, 5000);
            return shaped(OP_TICK, value);
        end else if (pick < 72) begin
            value = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 255)) - 128
                                                : int'($urandom_range(0, 200)) - 100;
            return shaped(OP_ENCODER, value);
        end else if (pick < 93) begin
            if ($urandom_range(0, 6) == 0) begin
                value = int'($urandom_range(0, 65535)) - 32768;
            end else begin
                value = int'($urandom_range(0, target_limit + 1000)) - 500;
                if (value > 32767) begin
                    value = 32767;
                end
            end
            return shaped(OP_SET, value);
        end
        return shaped(OP_UNUSED, 0);
    endfunction

    // Writes one calibration register and updates our copy once the write has landed.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_GAIN:       cal_gain     = data;
            CFG_OFFSET:     cal_offset   = longint'($signed(data[OFFSET_W-1:0]));
            CFG_TARGET_MAX: target_limit = data[TARGET_W-1:0];
            CFG_FULL_SCALE: full_scale   = data[FULL_SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_calibration(input int gain, input int offset, input int tmax,
                                   input int fs);
        write_reg(CFG_GAIN,       CFG_DATA_W'(gain));
        write_reg(CFG_OFFSET,     CFG_DATA_W'(offset));
        write_reg(CFG_TARGET_MAX, CFG_DATA_W'(tmax));
        write_reg(CFG_FULL_SCALE, CFG_DATA_W'(fs));
        cfg_phases++;
    endtask

    // Waits until every request has gone in and every result has come back, then lets the
    // pipeline settle so that registers can be written safely. The check is made just after
    // the edge, once the driver and the monitor have both settled for that cycle.
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (requests_pending.size() != 0 || in_if.valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: offers requests in bursts separated by random gaps, or back to back when the
    // sender is held steady. The result of a request is predicted at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                results_due.push_back(regulate(offered));
            end
            // A request not yet taken stays on the channel unchanged.
            if (!(in_if.valid && !in_if.ready)) begin
                if (gap_left > 0 && !sender_steady) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (requests_pending.size() != 0) begin
                    offered = requests_pending.pop_front();
                    in_if.valid             <= 1'b1;
                    in_if.opcode            <= offered.opcode;
                    in_if.sense_mv          <= offered.sense_mv;
                    in_if.encoder_count     <= offered.encoder_count;
                    in_if.target_request_ma <= offered.target_request_ma;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Compares one field of a result and reports a difference.
    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
                $display("%0t ns: result %0d, %s expected %0d, got %0d",
                         $time, results_seen, field, want, got);
            end
        end
    endfunction

    // Monitor: checks each accepted result against the oldest prediction and paces ready.
    // The receiver cycles through its own stall patterns and twice holds off for a long
    // stretch, so that the regulator fills up and has to refuse requests.
    always @(posedge i_clk) begin
        t_result want;

        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            mode_timer = 0;
            hold_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result arrived with nothing predicted, dac_code %0d",
                             $time, out_if.dac_code);
                end else begin
                    want = results_due.pop_front();
                    check_field("dac_code", want.dac_code, out_if.dac_code);
                    check_field("target_ma", want.target_ma, out_if.target_ma);
                    check_field("sensed_ma", want.sensed_ma, out_if.sensed_ma);
                    check_field("encoder_consumed", want.encoder_consumed,
                                out_if.encoder_consumed);
                end
                results_seen++;
                if (results_seen == 300 || results_seen == 600) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (mode_timer == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_timer = 80;
            end else begin
                mode_timer--;
            end
            if (hold_left > 0) begin
                hold_left--;
                take_result = 1'b0;
            end else begin
                case (stall_mode)
                    0:       take_result = 1'b1;
                    1:       take_result = ($urandom_range(0, 3) != 0);
                    2:       take_result = ((mode_timer % 3) != 0);
                    default: take_result = ($urandom_range(0, 9) < 4);
                endcase
            end
            out_if.ready <= take_result;
        end
    end

    // Stimulus: directed checks first, then phases of random requests under several
    // calibrations, each phase separated by a drain so that registers change only when idle.
    initial begin
        int goal;
        int mv;

        i_rst_n                 = 1'b0;
        i_cfg_wr_en             = 1'b0;
        i_cfg_index             = CFG_GAIN;
        i_cfg_wdata             = '0;
        in_if.valid             = 1'b0;
        in_if.opcode            = OP_TICK;
        in_if.sense_mv          = '0;
        in_if.encoder_count     = '0;
        in_if.target_request_ma = '0;
        out_if.ready            = 1'b0;
        sender_steady           = 1'b0;

        cal_gain     = GAIN_RESET;
        cal_offset   = 0;
        target_limit = TARGET_MAX_RESET;
        full_scale   = FULL_SCALE_RESET;
        model_dac    = 0;
        model_target = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset calibration. A zero target against a zero reading
        // must leave the code alone; small encoder counts must be ignored; both ends of every
        // field are exercised.
        requests_pending.push_back(shaped(OP_TICK, 0));
        requests_pending.push_back(shaped(OP_UNUSED, 0));
        requests_pending.push_back(shaped(OP_ENCODER, 0));
        requests_pending.push_back(shaped(OP_ENCODER, 1));
        requests_pending.push_back(shaped(OP_ENCODER, -1));
        requests_pending.push_back(shaped(OP_ENCODER, -2));
        requests_pending.push_back(shaped(OP_ENCODER, 100));
        requests_pending.push_back(shaped(OP_ENCODER, 127));
        requests_pending.push_back(shaped(OP_ENCODER, -128));
        requests_pending.push_back(shaped(OP_ENCODER, -100));
        requests_pending.push_back(shaped(OP_SET, 32767));
        requests_pending.push_back(shaped(OP_SET, -32768));
        requests_pending.push_back(shaped(OP_SET, 600));
        requests_pending.push_back(shaped(OP_TICK, 0));
        requests_pending.push_back(shaped(OP_TICK, 8191));
        requests_pending.push_back(shaped(OP_SET, 0));
        // Driving the code down into zero checks the lower saturation.
        requests_pending.push_back(shaped(OP_TICK, 8191));
        requests_pending.push_back(shaped(OP_TICK, 8191));
        requests_pending.push_back(shaped(OP_TICK, 8191));
        requests_pending.push_back(shaped(OP_SET, 5));
        requests_pending.push_back(shaped(OP_TICK, 5));
        requests_pending.push_back(shaped(OP_TICK, 5000));
        drain();

        // All but the offset at the top: the calibrated reading overflows and saturates.
        set_calibration(65535, 1000, 32767, 32767);
        requests_pending.push_back(shaped(OP_TICK, 8191));
        repeat (100) requests_pending.push_back(random_request());
        drain();

        // Every register but the offset at its bottom.
        set_calibration(0, -1000, 0, 0);
        repeat (40) requests_pending.push_back(random_request());
        drain();

        // A ramp: with no gain the reading is zero and with no full scale the estimate
        // never overshoots, so each tick climbs one code. The sender runs flat out here
        // while the receiver takes one of its long pauses.
        set_calibration(0, -1000, 32767, 0);
        sender_steady = 1'b1;
        requests_pending.push_back(shaped(OP_SET, 32767));
        repeat (RAMP_TICKS) begin
            requests_pending.push_back(shaped(OP_TICK, $urandom_range(0, 8191)));
        end
        drain();

        // From the code reached by the ramp, with a large full scale, a modest target makes
        // the tick step back rather than overshoot.
        sender_steady = 1'b0;
        write_reg(CFG_FULL_SCALE, CFG_DATA_W'(32767));
        requests_pending.push_back(shaped(OP_SET, 1000));
        repeat (20) requests_pending.push_back(shaped(OP_TICK, $urandom_range(0, 8191)));
        repeat (60) requests_pending.push_back(random_request());
        drain();

        // Lowering the target limit must not touch the target already held until the next
        // encoder or set request clamps it.
        set_calibration(GAIN_RESET, 0, TARGET_MAX_RESET, FULL_SCALE_RESET);
        requests_pending.push_back(shaped(OP_SET, 2500));
        drain();
        write_reg(CFG_TARGET_MAX, CFG_DATA_W'(100));
        requests_pending.push_back(shaped(OP_TICK, 0));
        requests_pending.push_back(shaped(OP_TICK, 300));
        requests_pending.push_back(shaped(OP_ENCODER, 4));
        repeat (50) requests_pending.push_back(random_request());
        drain();

        // Random calibrations, alternating bursty and back-to-back offering.
        for (int p = 0; p < 5; p++) begin
            set_calibration($urandom_range(0, 65535), int'($urandom_range(0, 2000)) - 1000,
                            $urandom_range(0, 32767), $urandom_range(0, 32767));
            sender_steady = (p % 2 == 1);
            repeat (40) requests_pending.push_back(random_request());
            drain();
        end
        sender_steady = 1'b0;

        // Closed-loop behaviour near the default calibration: a target is set and the
        // readings then hover around it, so the step and step-back decisions both fire.
        set_calibration(GAIN_RESET, 0, TARGET_MAX_RESET, FULL_SCALE_RESET);
        repeat (15) begin
            goal = $urandom_range(0, 2500);
            requests_pending.push_back(shaped(OP_SET, goal));
            repeat (10) begin
                mv = goal + int'($urandom_range(0, 120)) - 60;
                if (mv < 0) begin
                    mv = 0;
                end
                requests_pending.push_back(shaped(OP_TICK, mv));
            end
            requests_pending.push_back(random_request());
        end
        drain();

        $display("Covered %0d ticks, %0d applied encoder steps, %0d sets and %0d unused opcodes",
                 ticks_seen, encoder_applied, sets_seen, unused_seen);
        $display("over %0d calibrations; %0d step-backs, %0d saturated steps, %0d mismatches.",
                 cfg_phases, step_backs, dac_saturations, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/dsc_pkg.sv
hdl/dsc_if.sv
hdl/dac_step_current_regulator_top.sv
tb/dac_step_current_regulator_top_tb.sv
